/* rtl/assert_macros.svh */
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IMA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ima_pkg.sv */
package ima_pkg;

    localparam int unsigned IMA_MAX_SNPS       = 1048576;
    localparam int unsigned IMA_FREQ_FRAC_BITS = 16;

    localparam int unsigned GENO_W    = 3;
    localparam int unsigned FREQ_W    = 17;
    localparam int unsigned COUNT_W   = 21;
    localparam int unsigned SUM_W     = 62;
    localparam int unsigned TERM_W    = 33;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned NUM_TERMS = 14;
    localparam int unsigned NUM_SUMS  = 5;

    localparam logic [1:0] PAIR_HH = 2'd0;
    localparam logic [1:0] PAIR_HD = 2'd1;

    localparam logic signed [GENO_W-1:0] GENO_MISSING = -3'sd1;
    localparam logic signed [GENO_W-1:0] GENO_ZERO    = 3'sd0;
    localparam logic signed [GENO_W-1:0] GENO_ONE     = 3'sd1;
    localparam logic signed [GENO_W-1:0] GENO_TWO     = 3'sd2;

    typedef enum logic [1:0] {
        MODE_HH,
        MODE_HD,
        MODE_DD
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_MUL,
        OP_ADD
    } op_kind_t;

    typedef enum logic [3:0] {
        T_P,
        T_Q,
        T_P2,
        T_Q2,
        T_PQ,
        T_P3,
        T_Q3,
        T_P2Q,
        T_PQ2,
        T_P4,
        T_Q4,
        T_P3Q,
        T_PQ3,
        T_P2Q2
    } term_t;

    typedef enum logic [2:0] {
        SUM_A00,
        SUM_A01,
        SUM_A02,
        SUM_A11,
        SUM_A12
    } sum_t;

    typedef struct packed {
        op_kind_t   kind;
        term_t      src;
        logic       b_is_q;
        term_t      dst;
        sum_t       sum;
        logic [1:0] shift;
        logic       last;
    } ima_op_t;

    typedef struct packed {
        logic    load;
        logic    run;
        logic    clear;
        ima_op_t op;
    } ima_ctrl_t;

    function automatic mode_t decode_mode(input logic [1:0] code);
        mode_t m;
        unique case (code)
            PAIR_HH: m = MODE_HH;
            PAIR_HD: m = MODE_HD;
            default: m = MODE_DD;
        endcase
        return m;
    endfunction

    function automatic ima_op_t mk_nop(input logic last);
        ima_op_t op;
        op      = '0;
        op.kind = OP_NOP;
        op.last = last;
        return op;
    endfunction

    function automatic ima_op_t mk_mul(input term_t src, input logic b_is_q, input term_t dst);
        ima_op_t op;
        op        = '0;
        op.kind   = OP_MUL;
        op.src    = src;
        op.b_is_q = b_is_q;
        op.dst    = dst;
        return op;
    endfunction

    function automatic ima_op_t mk_add(input sum_t sum, input term_t src,
                                       input logic [1:0] shift, input logic last);
        ima_op_t op;
        op       = '0;
        op.kind  = OP_ADD;
        op.sum   = sum;
        op.src   = src;
        op.shift = shift;
        op.last  = last;
        return op;
    endfunction

    // sequencer program per pairing rule; a mul product passes prod_reg, then term_reg
    function automatic ima_op_t ima_microcode(input mode_t mode, input logic [STEP_W-1:0] step);
        ima_op_t op;
        op = mk_nop(1'b1);
        unique case (mode)
            MODE_HH:
            begin
                unique case (step)
                    5'd0:    op = mk_mul(T_P, 1'b0, T_P2);
                    5'd1:    op = mk_mul(T_Q, 1'b1, T_Q2);
                    5'd2:    op = mk_mul(T_P, 1'b1, T_PQ);
                    5'd3:    op = mk_nop(1'b0);
                    5'd4:    op = mk_add(SUM_A00, T_PQ, 2'd1, 1'b0);
                    5'd5:    op = mk_add(SUM_A01, T_P2, 2'd0, 1'b0);
                    5'd6:    op = mk_add(SUM_A01, T_Q2, 2'd0, 1'b1);
                    default: op = mk_nop(1'b1);
                endcase
            end
            MODE_HD:
            begin
                unique case (step)
                    5'd0:    op = mk_mul(T_P, 1'b0, T_P2);
                    5'd1:    op = mk_mul(T_Q, 1'b1, T_Q2);
                    5'd2:    op = mk_mul(T_P2, 1'b0, T_P3);
                    5'd3:    op = mk_mul(T_Q2, 1'b1, T_Q3);
                    5'd4:    op = mk_mul(T_P2, 1'b1, T_P2Q);
                    5'd5:    op = mk_mul(T_Q2, 1'b0, T_PQ2);
                    5'd6:    op = mk_nop(1'b0);
                    5'd7:    op = mk_add(SUM_A00, T_P2Q, 2'd0, 1'b0);
                    5'd8:    op = mk_add(SUM_A00, T_PQ2, 2'd0, 1'b0);
                    5'd9:    op = mk_add(SUM_A01, T_P3, 2'd0, 1'b0);
                    5'd10:   op = mk_add(SUM_A01, T_Q3, 2'd0, 1'b0);
                    5'd11:   op = mk_add(SUM_A01, T_P2Q, 2'd1, 1'b0);
                    5'd12:   op = mk_add(SUM_A01, T_PQ2, 2'd1, 1'b1);
                    default: op = mk_nop(1'b1);
                endcase
            end
            MODE_DD:
            begin
                unique case (step)
                    5'd0:    op = mk_mul(T_P, 1'b0, T_P2);
                    5'd1:    op = mk_mul(T_Q, 1'b1, T_Q2);
                    5'd2:    op = mk_mul(T_P2, 1'b0, T_P3);
                    5'd3:    op = mk_mul(T_Q2, 1'b1, T_Q3);
                    5'd4:    op = mk_mul(T_P2, 1'b1, T_P2Q);
                    5'd5:    op = mk_mul(T_Q2, 1'b0, T_PQ2);
                    5'd6:    op = mk_mul(T_P3, 1'b0, T_P4);
                    5'd7:    op = mk_mul(T_Q3, 1'b1, T_Q4);
                    5'd8:    op = mk_mul(T_P3, 1'b1, T_P3Q);
                    5'd9:    op = mk_mul(T_Q3, 1'b0, T_PQ3);
                    5'd10:   op = mk_mul(T_P2Q, 1'b1, T_P2Q2);
                    5'd11:   op = mk_nop(1'b0);
                    5'd12:   op = mk_add(SUM_A00, T_P2Q2, 2'd1, 1'b0);
                    5'd13:   op = mk_add(SUM_A01, T_P3Q, 2'd2, 1'b0);
                    5'd14:   op = mk_add(SUM_A01, T_PQ3, 2'd2, 1'b0);
                    5'd15:   op = mk_add(SUM_A02, T_P4, 2'd0, 1'b0);
                    5'd16:   op = mk_add(SUM_A02, T_Q4, 2'd0, 1'b0);
                    5'd17:   op = mk_add(SUM_A02, T_P2Q2, 2'd2, 1'b0);
                    5'd18:   op = mk_add(SUM_A11, T_P2Q, 2'd1, 1'b0);
                    5'd19:   op = mk_add(SUM_A11, T_PQ2, 2'd1, 1'b0);
                    5'd20:   op = mk_add(SUM_A12, T_P3, 2'd0, 1'b0);
                    5'd21:   op = mk_add(SUM_A12, T_Q3, 2'd0, 1'b0);
                    5'd22:   op = mk_add(SUM_A12, T_P2Q, 2'd0, 1'b0);
                    5'd23:   op = mk_add(SUM_A12, T_PQ2, 2'd0, 1'b1);
                    default: op = mk_nop(1'b1);
                endcase
            end
            default: op = mk_nop(1'b1);
        endcase
        return op;
    endfunction

endpackage

/* rtl/ima_ctrl.sv */
`include "assert_macros.svh"

module ima_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snp_valid,
    input  logic              snp_present,
    input  logic              snp_last,
    input  ima_pkg::mode_t    mode,
    input  logic              res_ready,
    output logic              snp_ready,
    output logic              res_valid,
    output ima_pkg::ima_ctrl_t ctrl
);
    import ima_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                last_reg, last_next;
    logic                res_valid_reg, res_valid_next;
    ima_op_t             op;

    assign op = ima_microcode(mode, step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        snp_ready  = 1'b0;
        ctrl       = '0;
        ctrl.op    = op;
        unique case (state_reg)
            S_IDLE:
            begin
                snp_ready = 1'b1;
                if (snp_valid)
                begin
                    ctrl.load = 1'b1;
                    last_next = snp_last;
                    step_next = '0;
                    if (snp_present)
                        state_next = S_RUN;
                    else if (snp_last)
                        state_next = S_EMIT;
                end
            end
            S_RUN:
            begin
                ctrl.run = 1'b1;
                if (op.last)
                    state_next = last_reg ? S_EMIT : S_IDLE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    ctrl.clear = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (ctrl.clear)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    assign res_valid = res_valid_reg;

    `IMA_ASSERT_IMPL(a_no_overwrite, ctrl.clear, !res_valid_reg || res_ready, "result overwritten")
    `IMA_ASSERT_NEXT(a_run_starts, snp_valid && snp_ready && snp_present, state_reg == S_RUN && step_reg == '0, "run did not start")
    `IMA_ASSERT_NEXT(a_run_ends, state_reg == S_RUN && op.last, state_reg != S_RUN, "run did not end")

endmodule

/* rtl/ima_mul_round.sv */
module ima_mul_round #(
    parameter int unsigned FREQ_FRAC_BITS = ima_pkg::IMA_FREQ_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [ima_pkg::TERM_W-1:0]  a,
    input  logic [FREQ_FRAC_BITS:0]     b,
    input  ima_pkg::term_t              dst,
    output logic                        wr_en,
    output ima_pkg::term_t              wr_dst,
    output logic [ima_pkg::TERM_W-1:0]  wr_data
);
    import ima_pkg::*;

    localparam int unsigned FW     = FREQ_FRAC_BITS + 1;
    localparam int unsigned PROD_W = TERM_W + FW;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FREQ_FRAC_BITS - 1);

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [PROD_W-1:0] rnd;
    term_t             dst_reg;
    logic              vld_reg;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= en;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            dst_reg  <= dst;
        end
    end

    // round to nearest, back to q.32
    assign rnd     = prod_reg + HALF;
    assign wr_en   = vld_reg;
    assign wr_dst  = dst_reg;
    assign wr_data = rnd[FREQ_FRAC_BITS+TERM_W-1:FREQ_FRAC_BITS];

endmodule

/* rtl/ima_poly_acc.sv */
`include "assert_macros.svh"

module ima_poly_acc #(
    parameter int unsigned FREQ_FRAC_BITS = ima_pkg::IMA_FREQ_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ima_pkg::ima_ctrl_t          ctrl,
    input  logic [ima_pkg::FREQ_W-1:0]  allele_freq,
    output logic [ima_pkg::SUM_W-1:0]   sums [ima_pkg::NUM_SUMS]
);
    import ima_pkg::*;

    localparam int unsigned FW    = FREQ_FRAC_BITS + 1;
    localparam int unsigned ADD_W = TERM_W + 3;
    localparam logic [31:0] ONE32 = 32'(1) << FREQ_FRAC_BITS;

    logic [FW-1:0]     p_reg;
    logic [FW-1:0]     q_val;
    logic [FW-1:0]     p_load;
    logic [31:0]       freq32;
    logic [TERM_W-1:0] p32, q32, src_val;
    logic [TERM_W-1:0] term_reg [NUM_TERMS];
    logic [SUM_W-1:0]  sum_reg [NUM_SUMS];
    logic [ADD_W-1:0]  addend;
    logic [SUM_W:0]    sum_raw;
    logic [SUM_W-1:0]  sum_sat;
    logic              mul_en;
    logic              term_wr_en;
    term_t             term_wr_dst;
    logic [TERM_W-1:0] term_wr_data;

    // frequency above one is clamped
    assign freq32 = 32'(allele_freq);
    assign p_load = (freq32 > ONE32) ? FW'(ONE32) : FW'(freq32);
    assign q_val  = FW'(ONE32) - p_reg;
    assign p32    = {p_reg, {(TERM_W - FW){1'b0}}};
    assign q32    = {q_val, {(TERM_W - FW){1'b0}}};

    always_comb
    begin
        unique case (ctrl.op.src)
            T_P:     src_val = p32;
            T_Q:     src_val = q32;
            default: src_val = term_reg[ctrl.op.src];
        endcase
    end

    assign mul_en = ctrl.run && (ctrl.op.kind == OP_MUL);

    ima_mul_round #(
        .FREQ_FRAC_BITS(FREQ_FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (mul_en),
        .a       (src_val),
        .b       (ctrl.op.b_is_q ? q_val : p_reg),
        .dst     (ctrl.op.dst),
        .wr_en   (term_wr_en),
        .wr_dst  (term_wr_dst),
        .wr_data (term_wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            p_reg <= p_load;
        if (term_wr_en)
            term_reg[term_wr_dst] <= term_wr_data;
    end

    // saturating accumulate at 2^62-1
    assign addend  = ADD_W'(src_val) << ctrl.op.shift;
    assign sum_raw = {1'b0, sum_reg[ctrl.op.sum]} + (SUM_W + 1)'(addend);
    assign sum_sat = sum_raw[SUM_W] ? {SUM_W{1'b1}} : sum_raw[SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
                sum_reg[i] <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < NUM_SUMS; i++)
                sum_reg[i] <= '0;
        end
        else if (ctrl.run && (ctrl.op.kind == OP_ADD))
        begin
            sum_reg[ctrl.op.sum] <= sum_sat;
        end
    end

    assign sums = sum_reg;

    `IMA_ASSERT_IMPL(a_no_term_hazard, ctrl.run && ctrl.op.kind == OP_ADD, !term_wr_en, "term written during add")

endmodule

/* rtl/ima_ibs_count.sv */
module ima_ibs_count #(
    parameter int unsigned MAX_SNPS = ima_pkg::IMA_MAX_SNPS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              inc,
    input  logic                              clear,
    input  ima_pkg::mode_t                    mode,
    input  logic signed [ima_pkg::GENO_W-1:0] geno_a,
    input  logic signed [ima_pkg::GENO_W-1:0] geno_b,
    output logic [ima_pkg::COUNT_W-1:0]       ibs0_count,
    output logic [ima_pkg::COUNT_W-1:0]       ibs1_count,
    output logic [ima_pkg::COUNT_W-1:0]       ibs2_count,
    output logic [ima_pkg::COUNT_W-1:0]       valid_count
);
    import ima_pkg::*;

    localparam longint unsigned FIELD_MAX = (64'd1 << COUNT_W) - 64'd1;
    localparam logic [COUNT_W-1:0] CAP =
        (64'(MAX_SNPS) < FIELD_MAX) ? COUNT_W'(MAX_SNPS) : COUNT_W'(FIELD_MAX);

    logic [COUNT_W-1:0] ibs0_reg, ibs1_reg, ibs2_reg, valid_reg;
    logic               hit0, hit1, hit2;
    logic               same, het_a, het_b;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c < CAP) ? c + COUNT_W'(1) : c;
    endfunction

    assign same  = (geno_a == geno_b);
    assign het_a = (geno_a == GENO_ONE) && ((geno_b == GENO_ZERO) || (geno_b == GENO_TWO));
    assign het_b = (geno_b == GENO_ONE) && ((geno_a == GENO_ZERO) || (geno_a == GENO_TWO));

    always_comb
    begin
        hit0 = 1'b0;
        hit1 = 1'b0;
        hit2 = 1'b0;
        unique case (mode)
            MODE_HH:
            begin
                hit1 = same;
                hit0 = !same;
            end
            MODE_HD:
            begin
                hit1 = same || (geno_a == GENO_ONE) || (geno_b == GENO_ONE);
                hit0 = !hit1;
            end
            default:
            begin
                hit2 = same;
                hit1 = het_a || het_b;
                hit0 = ((geno_a == GENO_ZERO) && (geno_b == GENO_TWO)) ||
                       ((geno_a == GENO_TWO) && (geno_b == GENO_ZERO));
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ibs0_reg  <= '0;
            ibs1_reg  <= '0;
            ibs2_reg  <= '0;
            valid_reg <= '0;
        end
        else if (clear)
        begin
            ibs0_reg  <= '0;
            ibs1_reg  <= '0;
            ibs2_reg  <= '0;
            valid_reg <= '0;
        end
        else if (inc)
        begin
            valid_reg <= sat_inc(valid_reg);
            if (hit0)
                ibs0_reg <= sat_inc(ibs0_reg);
            if (hit1)
                ibs1_reg <= sat_inc(ibs1_reg);
            if (hit2)
                ibs2_reg <= sat_inc(ibs2_reg);
        end
    end

    assign ibs0_count  = ibs0_reg;
    assign ibs1_count  = ibs1_reg;
    assign ibs2_count  = ibs2_reg;
    assign valid_count = valid_reg;

endmodule

/* rtl/ibs_moment_accumulator_unit.sv */
// Per-pair IBS moment accumulator. One SNP transaction is taken when the block is idle; a SNP
// with both calls present then runs a short program on one shared 33 x (FREQ_FRAC_BITS+1) bit
// multiplier with rounding and one saturating 63-bit adder, and the next SNP is taken only
// once that program is through. A SNP with a missing call runs no program. On the last SNP an
// emit step moves counts and sums to the result register and clears them; a result still
// waiting there holds that step until it is taken. Pairing is latched through cfg_wr_en and is
// to be written only between transactions; the user is bound to this, the block does not enforce
// it. Code 3 acts as diploid-diploid. Counts saturate at MAX_SNPS or at the 21-bit field maximum
// if that is less, sums at 2^62-1, and there is no clearing pass after reset.
module ibs_moment_accumulator_unit #(
    parameter int unsigned MAX_SNPS       = ima_pkg::IMA_MAX_SNPS,
    parameter int unsigned FREQ_FRAC_BITS = ima_pkg::IMA_FREQ_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_wr_data,
    input  logic                              snp_valid,
    output logic                              snp_ready,
    input  logic signed [ima_pkg::GENO_W-1:0] geno_a,
    input  logic signed [ima_pkg::GENO_W-1:0] geno_b,
    input  logic [ima_pkg::FREQ_W-1:0]        allele_freq,
    input  logic                              last_snp,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [ima_pkg::COUNT_W-1:0]       ibs0_count,
    output logic [ima_pkg::COUNT_W-1:0]       ibs1_count,
    output logic [ima_pkg::COUNT_W-1:0]       ibs2_count,
    output logic [ima_pkg::COUNT_W-1:0]       valid_count,
    output logic [ima_pkg::SUM_W-1:0]         sum_a00,
    output logic [ima_pkg::SUM_W-1:0]         sum_a01,
    output logic [ima_pkg::SUM_W-1:0]         sum_a02,
    output logic [ima_pkg::SUM_W-1:0]         sum_a11,
    output logic [ima_pkg::SUM_W-1:0]         sum_a12
);
    import ima_pkg::*;

    logic [1:0]         ploidy_reg;
    mode_t              mode;
    logic               present;
    ima_ctrl_t          ctrl;
    logic [COUNT_W-1:0] c0, c1, c2, cv;
    logic [SUM_W-1:0]   sums [NUM_SUMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ploidy_reg <= MODE_DD;
        else if (cfg_wr_en)
            ploidy_reg <= cfg_wr_data;
    end

    assign mode    = decode_mode(ploidy_reg);
    assign present = (geno_a != GENO_MISSING) && (geno_b != GENO_MISSING);

    ima_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .snp_valid   (snp_valid),
        .snp_present (present),
        .snp_last    (last_snp),
        .mode        (mode),
        .res_ready   (res_ready),
        .snp_ready   (snp_ready),
        .res_valid   (res_valid),
        .ctrl        (ctrl)
    );

    ima_ibs_count #(
        .MAX_SNPS(MAX_SNPS)
    ) u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .inc         (ctrl.load && present),
        .clear       (ctrl.clear),
        .mode        (mode),
        .geno_a      (geno_a),
        .geno_b      (geno_b),
        .ibs0_count  (c0),
        .ibs1_count  (c1),
        .ibs2_count  (c2),
        .valid_count (cv)
    );

    ima_poly_acc #(
        .FREQ_FRAC_BITS(FREQ_FRAC_BITS)
    ) u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .allele_freq (allele_freq),
        .sums        (sums)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            ibs0_count  <= c0;
            ibs1_count  <= c1;
            ibs2_count  <= c2;
            valid_count <= cv;
            sum_a00     <= sums[SUM_A00];
            sum_a01     <= sums[SUM_A01];
            sum_a02     <= sums[SUM_A02];
            sum_a11     <= sums[SUM_A11];
            sum_a12     <= sums[SUM_A12];
        end
    end

endmodule
